### src/assert_macros.svh
// Assertion helper macros for the rounding block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/rtic_pkg.sv
// ----------------------------------------------------------------------------
// rtic_pkg
// Shared types and constants for the round-to-integral / convert block.
// ----------------------------------------------------------------------------
package rtic_pkg;

  typedef enum logic [1:0] {
    KIND_RND_D = 2'd0,
    KIND_RND_S = 2'd1,
    KIND_CVT_D = 2'd2,
    KIND_CVT_S = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RM_RNE = 2'd0,
    RM_RDN = 2'd1,
    RM_RUP = 2'd2,
    RM_RTZ = 2'd3
  } rmode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NAN   = 2'd1,
    ST_RANGE = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam logic [0:0] REG_RMODE = 1'b0;

  localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] operand;
  } in_word_t;

  typedef struct packed {
    logic [63:0] value;
    logic        inexact;
    logic [1:0]  status;
  } out_word_t;

endpackage

### src/round_to_integral_and_convert.sv
// ----------------------------------------------------------------------------
// round_to_integral_and_convert
// IEEE rint / llrint on binary64 or binary32 with a configurable mode.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// in        start/busy start & !busy; busy is tied low
// result    strobe     one cycle pulse, no backpressure
// config    APB        psel & penable & pwrite, pready always 1
//
// One item per cycle; result strobes after start passes the input
// register, then the result register. Reset clears the mode to nearest-even
// and the strobe pipeline. Results cannot be stalled.
// ----------------------------------------------------------------------------
module round_to_integral_and_convert (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rtic_pkg::in_word_t  din,
  output logic                strobe,
  output rtic_pkg::out_word_t dout,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [1:0]          rmode;
  logic                in_vld;
  rtic_pkg::in_word_t  in_reg;
  rtic_pkg::out_word_t res;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr == rtic_pkg::REG_RMODE) ? {30'd0, rmode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rmode  <= rtic_pkg::RM_RNE;
      in_vld <= 1'b0;
      strobe <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == rtic_pkg::REG_RMODE)
        rmode <= pwdata[1:0];
      in_vld <= start;
      strobe <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    in_reg <= din;
    dout   <= res;
  end

  rtic_core u_core (
    .din   (in_reg),
    .rmode (rmode),
    .dout  (res)
  );

endmodule

### src/rtic_core.sv
// ----------------------------------------------------------------------------
// rtic_core
// Combinational round-to-integral on a unified 64-bit datapath, plus int64
// conversion of the rounded value.
// ----------------------------------------------------------------------------
module rtic_core (
  input  rtic_pkg::in_word_t  din,
  input  logic [1:0]          rmode,
  output rtic_pkg::out_word_t dout
);

  logic        dbl, cvt, sgn, special, zero, inx;
  logic [10:0] ef;
  logic [52:0] mant;      // hidden bit + fraction, binary32 left-aligned
  logic [62:0] mag;       // magnitude bits of the repacked rounded value
  logic [12:0] e;         // unbiased exponent, signed
  logic [5:0]  fr;
  logic [52:0] unit, mask, disc, half, rndm;
  logic [53:0] sum;
  logic        up, below1, gt_half;
  logic [63:0] rbits, rval;
  logic [10:0] re;        // exponent of rounded value (biased in the operand's format)
  logic [52:0] rm;
  logic [12:0] rexp;
  logic [63:0] ival, shifted;
  logic [62:0] frac_all;

  always_comb begin
    dbl  = ~din.kind[0];
    cvt  = din.kind[1];
    if (dbl) begin
      sgn  = din.operand[63];
      ef   = din.operand[62:52];
      frac_all = {din.operand[51:0], 11'd0};
      special = &din.operand[62:52];
      zero = din.operand[62:0] == 63'd0;
      e = {2'b0, ef} - 13'd1023;
      if (ef == 11'd0) e = 13'h1C02; // 1-1023
    end else begin
      sgn  = din.operand[31];
      ef   = {3'd0, din.operand[30:23]};
      frac_all = {din.operand[22:0], 40'd0};
      special = &din.operand[30:23];
      zero = din.operand[30:0] == 31'd0;
      e = {2'b0, ef} - 13'd127;
      if (ef == 11'd0) e = 13'h1F82; // 1-127
    end
    mant = {ef != 11'd0, frac_all[62:11]};
    mag = 63'd0;
    // fraction bits count from bit 52 of mant regardless of format
    below1 = e[12];
    fr = 6'd0;
    if (!below1 && e < 13'd52) fr = 6'd52 - e[5:0];
    unit = 53'd1 << fr;
    mask = unit - 53'd1;
    disc = mant & mask;
    half = unit >> 1;
    up = 1'b0;
    if ((rmode == rtic_pkg::RM_RUP && !sgn) || (rmode == rtic_pkg::RM_RDN && sgn))
      up = disc != 53'd0;
    else if (rmode == rtic_pkg::RM_RNE)
      up = (disc > half) || (disc == half && disc != 53'd0 && (mant & unit) != 53'd0);
    rndm = mant & ~mask;
    sum = {1'b0, rndm} + (up ? {1'b0, unit} : 54'd0);
    // magnitude > 1/2 for below-one: e==-1 with nonzero fraction
    gt_half = (e == 13'h1FFF) && (mant[51:0] != 52'd0);
    inx = 1'b0;
    // rounded value as (exponent, 53-bit mantissa with hidden bit)
    rexp = e;
    rm = rndm;
    if (special || zero) begin
      rm = 53'd0;
    end else if (below1) begin
      inx = 1'b1;
      if ((rmode == rtic_pkg::RM_RUP && !sgn) || (rmode == rtic_pkg::RM_RDN && sgn)
          || (rmode == rtic_pkg::RM_RNE && gt_half)) begin
        rexp = 13'd0;
        rm = {1'b1, 52'd0};
      end else begin
        rm = 53'd0;
      end
    end else if (!e[12] && e >= 13'd52) begin
      rm = mant;
    end else begin
      inx = disc != 53'd0;
      if (sum[53]) begin
        rexp = e + 13'd1;
        rm = sum[53:1];
      end else begin
        rm = sum[52:0];
      end
    end
    // repack rounded IEEE bits
    if (special || zero || (!below1 && e >= 13'd52)) begin
      rbits = dbl ? din.operand : {32'd0, din.operand[31:0]};
    end else if (rm == 53'd0) begin
      rbits = dbl ? {sgn, 63'd0} : {32'd0, sgn, 31'd0};
    end else if (dbl) begin
      re = rexp[10:0] + 11'd1023;
      rbits = {sgn, re, rm[51:0]};
    end else begin
      re = rexp[10:0] + 11'd127;
      rbits = {32'd0, sgn, re[7:0], rm[51:29]};
    end
    re = 11'd0;
    mag = rbits[62:0];
    // int64 conversion of (rexp, rm)
    shifted = 64'd0;
    if (rm != 53'd0 && rexp < 13'd63) begin
      if (rexp >= 13'd52) shifted = {11'd0, rm} << (rexp[5:0] - 6'd52);
      else shifted = {11'd0, rm} >> (6'd52 - rexp[5:0]);
    end
    ival = sgn ? (64'd0 - shifted) : shifted;
    dout.value   = rbits;
    dout.inexact = inx;
    dout.status  = rtic_pkg::ST_OK;
    if (cvt) begin
      dout.value = ival;
      if (special) begin
        dout.value = rtic_pkg::I64_MIN;
        dout.inexact = 1'b0;
        dout.status = rtic_pkg::ST_NAN;
      end else if (rm != 53'd0 && !rexp[12] && rexp >= 13'd63) begin
        if (sgn && rexp == 13'd63 && rm[51:0] == 52'd0) begin
          dout.value = rtic_pkg::I64_MIN;
        end else begin
          dout.value = rtic_pkg::I64_MIN;
          dout.inexact = 1'b0;
          dout.status = rtic_pkg::ST_RANGE;
        end
      end
    end
  end

  logic unused;
  assign unused = ^{mag, re};

endmodule

### src/rtic_checker.sv
// ----------------------------------------------------------------------------
// rtic_checker
// Port-level checks for the rounding block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rtic_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                strobe,
  input rtic_pkg::out_word_t dout
);
  `CHK_NEXT(a_lat, clk, rst, start && !$past(rst), ##1 strobe, "result missing")
  `CHK_IMPL(a_st, clk, rst, strobe, dout.status != rtic_pkg::ST_RSVD, "bad status")
  `CHK_IMPL(a_fail, clk, rst, strobe && dout.status != rtic_pkg::ST_OK,
            dout.value == rtic_pkg::I64_MIN && !dout.inexact, "failure word wrong")
endmodule

bind round_to_integral_and_convert rtic_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .strobe(strobe), .dout(dout)
);

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for round_to_integral_and_convert: a directed table of
// edge cases, a sweep of its tricky rows under every rounding mode, then bursts
// of random words under written modes. Each result word is compared with a table value or a bit-level predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  rtic_pkg::in_word_t  din = '0;
  logic                strobe;
  rtic_pkg::out_word_t dout;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [0:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  round_to_integral_and_convert uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rtic_pkg::rmode_t    cur_mode;     // predictor's copy of the mode register
  rtic_pkg::out_word_t pending[$];   // expected result words, oldest first
  int                  errors = 0;
  longint              cycles = 0;

  localparam longint CYCLE_LIMIT = 200000;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Round a finite/special pattern to integral in its own format.
  function automatic logic [63:0] rint_bits(input logic [63:0] bits, input bit dbl,
                                            output bit inx);
    int          fb, bias, e, fr;
    logic [63:0] signm, expm, halfb, oneb, sgn, mag, ef, emax, unit, msk, disc, rnd;
    fb    = dbl ? 52 : 23;
    bias  = dbl ? 1023 : 127;
    signm = dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
    expm  = dbl ? 64'h7ff0_0000_0000_0000 : 64'h7f80_0000;
    halfb = dbl ? 64'h3fe0_0000_0000_0000 : 64'h3f00_0000;
    oneb  = dbl ? 64'h3ff0_0000_0000_0000 : 64'h3f80_0000;
    inx   = 1'b0;
    sgn   = bits & signm;
    mag   = bits & ~signm & (signm | (signm - 1));
    ef    = (bits & expm) >> fb;
    emax  = expm >> fb;
    if (ef == emax || mag == 0) return bits;
    e = (ef == 0) ? 1 - bias : int'(ef) - bias;
    if (e < 0) begin
      inx = 1'b1;
      if (cur_mode == rtic_pkg::RM_RUP && sgn == 0) return oneb;
      if (cur_mode == rtic_pkg::RM_RDN && sgn != 0) return sgn | oneb;
      if (cur_mode == rtic_pkg::RM_RNE && mag > halfb) return sgn | oneb;
      return sgn;
    end
    if (e >= fb) return bits;
    fr   = fb - e;
    unit = 64'd1 << fr;
    msk  = unit - 1;
    disc = mag & msk;
    if (disc == 0) return bits;
    inx = 1'b1;
    rnd = mag & ~msk;
    if ((cur_mode == rtic_pkg::RM_RUP && sgn == 0) ||
        (cur_mode == rtic_pkg::RM_RDN && sgn != 0)) begin
      rnd += unit;
    end else if (cur_mode == rtic_pkg::RM_RNE) begin
      if (disc > (unit >> 1) || (disc == (unit >> 1) && (rnd & unit) != 0))
        rnd += unit;
    end
    return sgn | rnd;
  endfunction

  function automatic rtic_pkg::out_word_t predict_word(input rtic_pkg::in_word_t w);
    rtic_pkg::out_word_t r;
    bit                  dbl, inx, neg;
    int                  fb, bias, e;
    logic [63:0]         op, rb, expm, fracm, mag, m, v;
    dbl   = (w.kind == rtic_pkg::KIND_RND_D || w.kind == rtic_pkg::KIND_CVT_D);
    op    = dbl ? w.operand : {32'd0, w.operand[31:0]};
    fb    = dbl ? 52 : 23;
    bias  = dbl ? 1023 : 127;
    expm  = dbl ? 64'h7ff0_0000_0000_0000 : 64'h7f80_0000;
    fracm = dbl ? 64'h000f_ffff_ffff_ffff : 64'h007f_ffff;
    r = '0;
    rb = rint_bits(op, dbl, inx);
    if (w.kind == rtic_pkg::KIND_RND_D || w.kind == rtic_pkg::KIND_RND_S) begin
      r.value = rb;
      r.inexact = inx;
      r.status = rtic_pkg::ST_OK;
      return r;
    end
    if ((op & expm) == expm) begin
      r.value = rtic_pkg::I64_MIN;
      r.status = rtic_pkg::ST_NAN;
      return r;
    end
    neg = dbl ? rb[63] : rb[31];
    mag = rb & (dbl ? 64'h7fff_ffff_ffff_ffff : 64'h7fff_ffff);
    e   = int'((rb & expm) >> fb) - bias;
    r.inexact = inx;
    r.status  = rtic_pkg::ST_OK;
    if (mag == 0 || e < 0) begin
      r.value = '0;
    end else if (e >= 63) begin
      if (neg && e == 63 && (mag & fracm) == 0) begin
        r.value = rtic_pkg::I64_MIN;
      end else begin
        r.value = rtic_pkg::I64_MIN;
        r.status = rtic_pkg::ST_RANGE;
        r.inexact = 1'b0;
      end
    end else begin
      m = (mag & fracm) | (64'd1 << fb);
      v = (e >= fb) ? (m << (e - fb)) : (m >> (fb - e));
      r.value = neg ? -v : v;
    end
    return r;
  endfunction

  // Result checker: strobe is sampled at the edge that accepts the word.
  always @(posedge clk) begin
    rtic_pkg::out_word_t exp_w;
    if (!rst && strobe) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, dout);
        errors++;
      end else begin
        exp_w = pending.pop_front();
        if (dout.value !== exp_w.value)
          $display("%0t: value exp %h got %h", $realtime, exp_w.value, dout.value);
        if (dout.inexact !== exp_w.inexact)
          $display("%0t: inexact exp %b got %b", $realtime, exp_w.inexact, dout.inexact);
        if (dout.status !== exp_w.status)
          $display("%0t: status exp %0d got %0d", $realtime, exp_w.status, dout.status);
        if (dout !== exp_w) errors++;
      end
    end
  end

  // APB write: setup then access phase.
  task automatic write_mode(input rtic_pkg::rmode_t md);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= rtic_pkg::REG_RMODE; pwdata <= {30'd0, md};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cur_mode = md;
  endtask

  // Let every expected word drain, then let the bench settle.
  task automatic drain;
    @(posedge clk);
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Issue one word; the expected result is either given or predicted.
  task automatic send_word(input rtic_pkg::in_word_t w, input bit has_exp,
                           input rtic_pkg::out_word_t ew);
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b1;
    din   <= w;
    pending.push_back(has_exp ? ew : predict_word(w));
  endtask

  // Operand in a random class: mostly near-integral magnitudes, plus noise.
  function automatic logic [63:0] rand_operand(input bit dbl);
    logic [63:0] x;
    int          sel;
    x   = {$urandom, $urandom};
    sel = $urandom_range(0, 9);
    if (dbl) begin
      if (sel < 6) x[62:52] = 11'(1020 + $urandom_range(0, 70));
      else if (sel == 6) x[62:52] = 11'h7ff;
      else if (sel == 7) x[62:52] = 11'd0;
    end else begin
      if (sel < 6) x[30:23] = 8'(124 + $urandom_range(0, 70));
      else if (sel == 6) x[30:23] = 8'hff;
      else if (sel == 7) x[30:23] = 8'd0;
    end
    return x;
  endfunction

  typedef struct {
    rtic_pkg::kind_t     k;
    logic [63:0]         op;
    bit                  has_exp;
    rtic_pkg::out_word_t ew;
  } vec_t;

  vec_t dir_tab[$];

  function automatic rtic_pkg::out_word_t ow(input logic [63:0] v, input bit i,
                                             input rtic_pkg::status_t s);
    rtic_pkg::out_word_t o;
    o.value = v; o.inexact = i; o.status = s;
    return o;
  endfunction

  initial begin
    rtic_pkg::in_word_t  w;
    rtic_pkg::out_word_t none;
    int                  burst, gap;
    none = '0;
    cur_mode = rtic_pkg::RM_RNE;
    // Directed rows, reset mode nearest-even.
    dir_tab = '{
      '{rtic_pkg::KIND_RND_D, 64'h0, 1, ow(64'h0, 0, rtic_pkg::ST_OK)},
      '{rtic_pkg::KIND_RND_D, 64'h8000_0000_0000_0000, 1,
        ow(64'h8000_0000_0000_0000, 0, rtic_pkg::ST_OK)},
      '{rtic_pkg::KIND_RND_D, 64'h7ff0_0000_0000_0000, 1,
        ow(64'h7ff0_0000_0000_0000, 0, rtic_pkg::ST_OK)},
      '{rtic_pkg::KIND_RND_D, 64'h7ff8_0000_0000_0001, 1,
        ow(64'h7ff8_0000_0000_0001, 0, rtic_pkg::ST_OK)},
      '{rtic_pkg::KIND_RND_S, 64'hffff_ffff_ff80_0000, 1,
        ow(64'hff80_0000, 0, rtic_pkg::ST_OK)},
      '{rtic_pkg::KIND_RND_S, 64'hffff_ffff_7fc0_0000, 1,
        ow(64'h7fc0_0000, 0, rtic_pkg::ST_OK)},
      '{rtic_pkg::KIND_CVT_D, 64'h7ff0_0000_0000_0000, 1,
        ow(rtic_pkg::I64_MIN, 0, rtic_pkg::ST_NAN)},
      '{rtic_pkg::KIND_CVT_S, 64'h0000_0000_ffc0_0001, 1,
        ow(rtic_pkg::I64_MIN, 0, rtic_pkg::ST_NAN)},
      '{rtic_pkg::KIND_CVT_D, 64'h43e0_0000_0000_0000, 1,
        ow(rtic_pkg::I64_MIN, 0, rtic_pkg::ST_RANGE)},
      '{rtic_pkg::KIND_CVT_D, 64'hc3e0_0000_0000_0000, 1,
        ow(rtic_pkg::I64_MIN, 0, rtic_pkg::ST_OK)},
      '{rtic_pkg::KIND_CVT_S, 64'h0000_0000_5f00_0000, 1,
        ow(rtic_pkg::I64_MIN, 0, rtic_pkg::ST_RANGE)},
      '{rtic_pkg::KIND_CVT_S, 64'h0000_0000_df00_0000, 1,
        ow(rtic_pkg::I64_MIN, 0, rtic_pkg::ST_OK)},
      '{rtic_pkg::KIND_CVT_D, 64'h7fef_ffff_ffff_ffff, 1,
        ow(rtic_pkg::I64_MIN, 0, rtic_pkg::ST_RANGE)},
      '{rtic_pkg::KIND_RND_D, 64'h0000_0000_0000_0001, 0, none},  // subnormal
      '{rtic_pkg::KIND_RND_D, 64'h3fe0_0000_0000_0000, 0, none},  // exactly one half
      '{rtic_pkg::KIND_RND_D, 64'h3fe0_0000_0000_0001, 0, none},  // just over half
      '{rtic_pkg::KIND_RND_D, 64'h4004_0000_0000_0000, 0, none},  // 2.5 tie
      '{rtic_pkg::KIND_RND_S, 64'h0000_0000_c020_0000, 0, none},  // -2.5 tie
      '{rtic_pkg::KIND_CVT_D, 64'hc3df_ffff_ffff_ffff, 0, none},
      '{rtic_pkg::KIND_CVT_S, 64'h0000_0000_bf7f_ffff, 0, none},
      '{rtic_pkg::KIND_RND_D, 64'h4330_0000_0000_0001, 0, none},  // already integral
      '{rtic_pkg::KIND_CVT_D, 64'h3ff8_0000_0000_0000, 0, none}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i]) begin
      w.kind = dir_tab[i].k;
      w.operand = dir_tab[i].op;
      send_word(w, dir_tab[i].has_exp, dir_tab[i].ew);
    end
    drain();
    // Small directed sweep of the tricky rows under every mode.
    for (int md = 3; md >= 0; md--) begin
      write_mode(rtic_pkg::rmode_t'(md));
      for (int i = 13; i < dir_tab.size(); i++) begin
        w.kind = dir_tab[i].k;
        w.operand = dir_tab[i].op ^ (i[0] ? 64'h8000_0000_8000_0000 : 64'h0);
        send_word(w, 0, none);
      end
      drain();
    end
    // Random phases, each under a freshly written mode (nearest-even in the last).
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(rtic_pkg::rmode_t'(ph == 7 ? 0 : $urandom_range(0, 3)));
      for (int n = 0; n < 100; ) begin
        burst = (ph == 2) ? 100 : $urandom_range(1, 16);
        for (int b = 0; b < burst && n < 100; b++, n++) begin
          w.kind = rtic_pkg::kind_t'($urandom_range(0, 3));
          w.operand = rand_operand(w.kind == rtic_pkg::KIND_RND_D ||
                                   w.kind == rtic_pkg::KIND_CVT_D);
          send_word(w, 0, none);
        end
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          @(posedge clk);
          start <= 1'b0;
          repeat (gap - 1) @(posedge clk);
        end
        // Hold off until the pipe is empty.
        if (n == 50) drain();
      end
      drain();
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/rtic_pkg.sv
src/rtic_core.sv
src/round_to_integral_and_convert.sv
src/rtic_checker.sv
test/tb.sv
